>>> sv/dra_pkg.sv
// Shared constants, phase and status codes for the DNS reply address extractor.
package dra_pkg;

	localparam int MAX_MESSAGE = 512;
	localparam int POS_W       = $clog2(MAX_MESSAGE + 1);
	localparam int HDR_LAST    = 11;
	localparam int HDR_LEN     = 12;
	localparam int QFIXED_LEN  = 4;
	localparam int AFIXED_LAST = 9;

	localparam logic [15:0] QR_MASK    = 16'h8000;
	localparam logic [15:0] RCODE_MASK = 16'h000F;
	localparam logic [7:0]  PTR_MASK   = 8'hC0;
	localparam logic [15:0] TYPE_A     = 16'd1;
	localparam logic [15:0] A_DLEN     = 16'd4;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_QLEN   = 4'd1,
		PH_QLABEL = 4'd2,
		PH_QPTR   = 4'd3,
		PH_QFIXED = 4'd4,
		PH_ALEN   = 4'd5,
		PH_ALABEL = 4'd6,
		PH_APTR   = 4'd7,
		PH_AFIXED = 4'd8,
		PH_ADATA  = 4'd9,
		PH_DONE   = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND   = 3'd0,
		ST_RCODE   = 3'd1,
		ST_SHORT   = 3'd2,
		ST_BADID   = 3'd3,
		ST_NOTRESP = 3'd4,
		ST_NOADDR  = 3'd5
	} status_t;

endpackage

>>> sv/dra_if.sv
// Request channel interfaces: message bytes, results and the id register write.
interface dra_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dra_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] address;

	modport source (output valid, output status, output address, input ready);
	modport sink   (input valid, input status, input address, output ready);
endinterface

interface dra_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] expected_txid;

	modport source (output valid, output expected_txid, input ready);
	modport sink   (input valid, input expected_txid, output ready);
endinterface

>>> sv/dns_reply_address_extractor.sv
// A last byte passes from the input register into the result register.
// Throughput: one message byte per cycle; a byte enters while a result waits to be taken.
// Only a last byte waits, and only while the result register is still occupied.
// Reset (arst_n low, asynchronous) clears the parser, the id register and all valids.
// The id register is always ready; write it only while no message is in flight.
module dns_reply_address_extractor
	import dra_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	dra_byte_if.sink       msg,
	dra_result_if.source   result,
	dra_cfg_if.sink        cfg
);

	// Input register stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        go_s1;

	// Parser state
	logic [15:0]      txid_q;
	logic [POS_W-1:0] pos_q;
	phase_t           phase_q;
	logic [7:0]       lbl_q;
	logic [3:0]       fidx_q;
	logic [15:0]      id_q;
	logic [15:0]      flags_q;
	logic [15:0]      ans_q;
	logic [15:0]      rtype_q;
	logic [15:0]      rdl_q;
	logic [31:0]      acc_q;
	logic             found_q;
	logic [31:0]      faddr_q;

	// Next values after this byte
	logic [POS_W-1:0] pos_n;
	phase_t           phase_n;
	logic [7:0]       lbl_n;
	logic [3:0]       fidx_n;
	logic [15:0]      id_n;
	logic [15:0]      flags_n;
	logic [15:0]      ans_n;
	logic [15:0]      rtype_n;
	logic [15:0]      rdl_n;
	logic [31:0]      acc_n;
	logic             found_n;
	logic [31:0]      faddr_n;
	logic             end_rec;

	status_t          st_n;

	// Result register
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] addr_q;

	// A last byte may only leave the input stage when the result slot is free
	// or being emptied in this cycle.
	assign go_s1     = valid_s1 & (~last_s1 | ~out_valid_q | result.ready);
	assign msg.ready = ~valid_s1 | go_s1;
	assign cfg.ready = 1'b1;

	assign result.valid   = out_valid_q;
	assign result.status  = status_q;
	assign result.address = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txid_q <= '0;
		end else if (cfg.valid) begin
			txid_q <= cfg.expected_txid;
		end
	end

	// Capture the byte; hold it while a last byte waits for the result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
	end

	// Per-byte parse step. Bytes past the size limit are counted no further
	// and change nothing.
	always_comb begin
		pos_n   = pos_q;
		phase_n = phase_q;
		lbl_n   = lbl_q;
		fidx_n  = fidx_q;
		id_n    = id_q;
		flags_n = flags_q;
		ans_n   = ans_q;
		rtype_n = rtype_q;
		rdl_n   = rdl_q;
		acc_n   = acc_q;
		found_n = found_q;
		faddr_n = faddr_q;
		end_rec = 1'b0;

		if (pos_q < POS_W'(MAX_MESSAGE)) begin
			pos_n = pos_q + 1'b1;
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_W'(0))      id_n    = {byte_s1, 8'h00};
					else if (pos_q == POS_W'(1)) id_n    = {id_q[15:8], byte_s1};
					else if (pos_q == POS_W'(2)) flags_n = {byte_s1, 8'h00};
					else if (pos_q == POS_W'(3)) flags_n = {flags_q[15:8], byte_s1};
					else if (pos_q == POS_W'(6)) ans_n   = {byte_s1, 8'h00};
					else if (pos_q == POS_W'(7)) ans_n   = {ans_q[15:8], byte_s1};
					if (pos_q >= POS_W'(HDR_LAST)) phase_n = PH_QLEN;
				end
				PH_QLEN, PH_ALEN: begin
					if (byte_s1 == 8'h00) begin
						fidx_n  = '0;
						phase_n = (phase_q == PH_QLEN) ? PH_QFIXED : PH_AFIXED;
					end else if ((byte_s1 & PTR_MASK) == PTR_MASK) begin
						// Compression pointer: one more byte, then the fixed part
						phase_n = (phase_q == PH_QLEN) ? PH_QPTR : PH_APTR;
					end else begin
						lbl_n   = byte_s1;
						phase_n = (phase_q == PH_QLEN) ? PH_QLABEL : PH_ALABEL;
					end
				end
				PH_QLABEL, PH_ALABEL: begin
					lbl_n = lbl_q - 1'b1;
					if (lbl_n == 8'd0) phase_n = (phase_q == PH_QLABEL) ? PH_QLEN : PH_ALEN;
				end
				PH_QPTR: begin
					fidx_n  = '0;
					phase_n = PH_QFIXED;
				end
				PH_APTR: begin
					fidx_n  = '0;
					phase_n = PH_AFIXED;
				end
				PH_QFIXED: begin
					fidx_n = fidx_q + 1'b1;
					if (fidx_n >= 4'(QFIXED_LEN)) begin
						fidx_n  = '0;
						phase_n = (ans_q == 16'd0) ? PH_DONE : PH_ALEN;
					end
				end
				PH_AFIXED: begin
					if (fidx_q == 4'd0)      rtype_n = {byte_s1, 8'h00};
					else if (fidx_q == 4'd1) rtype_n = {rtype_q[15:8], byte_s1};
					else if (fidx_q == 4'd8) rdl_n   = {byte_s1, 8'h00};
					else if (fidx_q == 4'd9) rdl_n   = {rdl_q[15:8], byte_s1};
					if (fidx_q >= 4'(AFIXED_LAST)) begin
						// Mark the record as a usable address record
						fidx_n = (rtype_n == TYPE_A && rdl_n == A_DLEN) ? 4'd1 : 4'd0;
						acc_n  = '0;
						if (rdl_n == 16'd0) end_rec = 1'b1;
						else phase_n = PH_ADATA;
					end else begin
						fidx_n = fidx_q + 1'b1;
					end
				end
				PH_ADATA: begin
					acc_n = {acc_q[23:0], byte_s1};
					rdl_n = rdl_q - 1'b1;
					if (rdl_n == 16'd0) begin
						if (fidx_q == 4'd1) begin
							found_n = 1'b1;
							faddr_n = acc_n;
						end
						fidx_n  = '0;
						end_rec = 1'b1;
					end
				end
				PH_DONE: begin
					phase_n = PH_DONE;
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase

			if (end_rec) begin
				if (ans_q != 16'd0) ans_n = ans_q - 1'b1;
				phase_n = (ans_n == 16'd0 || found_n) ? PH_DONE : PH_ALEN;
			end
		end
	end

	// Status in priority order, from the state as it stands after this byte
	always_comb begin
		if (pos_n < POS_W'(HDR_LEN))             st_n = ST_SHORT;
		else if (id_n != txid_q)                 st_n = ST_BADID;
		else if ((flags_n & QR_MASK) == 16'd0)   st_n = ST_NOTRESP;
		else if ((flags_n & RCODE_MASK) != 16'd0) st_n = ST_RCODE;
		else if (found_n)                        st_n = ST_FOUND;
		else                                     st_n = ST_NOADDR;
	end

	// Advance the parser; drop back to the header phase after a last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			lbl_q   <= '0;
			fidx_q  <= '0;
			id_q    <= '0;
			flags_q <= '0;
			ans_q   <= '0;
			rtype_q <= '0;
			rdl_q   <= '0;
			acc_q   <= '0;
			found_q <= 1'b0;
			faddr_q <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				phase_q <= PH_HEADER;
				lbl_q   <= '0;
				fidx_q  <= '0;
				id_q    <= '0;
				flags_q <= '0;
				ans_q   <= '0;
				rtype_q <= '0;
				rdl_q   <= '0;
				acc_q   <= '0;
				found_q <= 1'b0;
				faddr_q <= '0;
			end else begin
				pos_q   <= pos_n;
				phase_q <= phase_n;
				lbl_q   <= lbl_n;
				fidx_q  <= fidx_n;
				id_q    <= id_n;
				flags_q <= flags_n;
				ans_q   <= ans_n;
				rtype_q <= rtype_n;
				rdl_q   <= rdl_n;
				acc_q   <= acc_n;
				found_q <= found_n;
				faddr_q <= faddr_n;
			end
		end
	end

	// Result register: load on a last byte, release when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			status_q <= st_n;
			addr_q   <= (st_n == ST_FOUND) ? faddr_n : 32'd0;
		end
	end

	a_addr_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == ST_FOUND || addr_q == 32'd0))
		else $error("address nonzero on a status other than found");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_MESSAGE))
		else $error("byte position beyond its limit");

	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && last_s1) |=> out_valid_q)
		else $error("last byte did not load the result register");

	a_last_clears_parser: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && last_s1) |=> (pos_q == '0 && phase_q == PH_HEADER && !found_q))
		else $error("parser not cleared after a last byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !(go_s1 && last_s1))
		else $error("result overwritten while waiting");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the DNS reply address extractor: tracker class and stimulus.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dra_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BYTES = 1850;
	localparam int PHASE_REPLY  = 1;
	localparam int CALM_BYTES   = 150;
	localparam int IDLE_PCT     = 26;
	localparam int DRAIN_CYCLES = 4;

	// name layouts for questions and answers
	localparam int NAME_PTR    = 0;
	localparam int NAME_LABELS = 1;
	localparam int NAME_MIXED  = 2;
	localparam int NAME_NONE   = 3;

	typedef struct packed {
		status_t     status;
		logic [31:0] address;
	} reply_t;

	// Tracks one DNS reply byte by byte and keeps the outcomes still owed by the block.
	class a_record_tracker;
		logic [15:0] txid;
		logic [15:0] pos;
		phase_t      ph;
		logic [7:0]  label_left;
		logic [3:0]  fidx;
		logic [15:0] hdr_id;
		logic [15:0] hdr_flags;
		logic [15:0] answers;
		logic [15:0] rtype;
		logic [15:0] rdlen;
		logic [31:0] acc;
		logic [31:0] addr_kept;
		bit          found;
		reply_t      awaited[$];
		int          faults;

		function new();
			txid = '0;
			faults = 0;
			restart();
		endfunction

		function void restart();
			pos = '0;
			ph = PH_HEADER;
			label_left = '0;
			fidx = '0;
			hdr_id = '0;
			hdr_flags = '0;
			answers = '0;
			rtype = '0;
			rdlen = '0;
			acc = '0;
			found = 1'b0;
			addr_kept = '0;
		endfunction

		function void close_record();
			if (answers != 16'd0)
				answers = answers - 16'd1;
			if (answers == 16'd0 || found)
				ph = PH_DONE;
			else
				ph = PH_ALEN;
		endfunction

		function void take_byte(logic [7:0] b, logic tail);
			reply_t     r;
			logic [3:0] i;
			if (pos < MAX_MESSAGE) begin
				case (ph)
					PH_HEADER: begin
						case (pos)
							16'd0: hdr_id = {b, 8'h00};
							16'd1: hdr_id = hdr_id | {8'h00, b};
							16'd2: hdr_flags = {b, 8'h00};
							16'd3: hdr_flags = hdr_flags | {8'h00, b};
							16'd6: answers = {b, 8'h00};
							16'd7: answers = answers | {8'h00, b};
							default: ;
						endcase
						if (pos >= HDR_LAST)
							ph = PH_QLEN;
					end
					PH_QLEN, PH_ALEN: begin
						if (b == 8'h00) begin
							fidx = '0;
							if (ph == PH_QLEN) ph = PH_QFIXED;
							else ph = PH_AFIXED;
						end else if ((b & PTR_MASK) == PTR_MASK) begin
							if (ph == PH_QLEN) ph = PH_QPTR;
							else ph = PH_APTR;
						end else begin
							label_left = b;
							if (ph == PH_QLEN) ph = PH_QLABEL;
							else ph = PH_ALABEL;
						end
					end
					PH_QLABEL, PH_ALABEL: begin
						label_left = label_left - 8'd1;
						if (label_left == 8'd0) begin
							if (ph == PH_QLABEL) ph = PH_QLEN;
							else ph = PH_ALEN;
						end
					end
					PH_QPTR: begin
						fidx = '0;
						ph = PH_QFIXED;
					end
					PH_APTR: begin
						fidx = '0;
						ph = PH_AFIXED;
					end
					PH_QFIXED: begin
						fidx = fidx + 4'd1;
						if (fidx >= QFIXED_LEN) begin
							fidx = '0;
							if (answers == 16'd0) ph = PH_DONE;
							else ph = PH_ALEN;
						end
					end
					PH_AFIXED: begin
						i = fidx;
						case (i)
							4'd0: rtype = {b, 8'h00};
							4'd1: rtype = rtype | {8'h00, b};
							4'd8: rdlen = {b, 8'h00};
							4'd9: rdlen = rdlen | {8'h00, b};
							default: ;
						endcase
						if (i >= AFIXED_LAST) begin
							// reuse the field counter as the usable-record mark
							fidx = (rtype == TYPE_A && rdlen == A_DLEN) ? 4'd1 : 4'd0;
							acc = '0;
							if (rdlen == 16'd0) close_record();
							else ph = PH_ADATA;
						end else begin
							fidx = i + 4'd1;
						end
					end
					PH_ADATA: begin
						acc = {acc[23:0], b};
						rdlen = rdlen - 16'd1;
						if (rdlen == 16'd0) begin
							if (fidx == 4'd1) begin
								found = 1'b1;
								addr_kept = acc;
							end
							fidx = '0;
							close_record();
						end
					end
					default: ph = PH_DONE;
				endcase
				pos = pos + 16'd1;
			end
			if (tail) begin
				if (pos < HDR_LEN) r.status = ST_SHORT;
				else if (hdr_id != txid) r.status = ST_BADID;
				else if ((hdr_flags & QR_MASK) == 16'd0) r.status = ST_NOTRESP;
				else if ((hdr_flags & RCODE_MASK) != 16'd0) r.status = ST_RCODE;
				else if (found) r.status = ST_FOUND;
				else r.status = ST_NOADDR;
				r.address = (r.status == ST_FOUND) ? addr_kept : 32'd0;
				awaited.push_back(r);
				restart();
			end
		endfunction

		function void note_fault(string text);
			faults++;
			if (faults <= 10)
				$display("mismatch: %s", text);
		endfunction

		function void match_reply(logic [2:0] status, logic [31:0] address);
			reply_t want;
			if (awaited.size() == 0) begin
				note_fault($sformatf("reply with no message pending: status %0d address %h",
					status, address));
				return;
			end
			want = awaited.pop_front();
			if (status !== want.status)
				note_fault($sformatf("status expected %0d got %0d", want.status, status));
			if (address !== want.address)
				note_fault($sformatf("address expected %h got %h", want.address, address));
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dra_byte_if   msg_ch ();
	dra_result_if res_ch ();
	dra_cfg_if    cfg_ch ();

	dns_reply_address_extractor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	a_record_tracker tracker;

	logic [7:0]  frame[$];      // message under construction
	logic [15:0] txid_now;      // id the block currently expects
	int          bytes_sent;
	int          random_replies;
	int          cycle_count;
	bit          calm;          // no idling on either side while set
	bit          hold_request;  // ask the result side for one long hold-off

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watch both channels; every request seen on the message side feeds the tracker,
	// every request on the result side is checked against the oldest outcome owed.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (msg_ch.valid && msg_ch.ready)
				tracker.take_byte(msg_ch.data_byte, msg_ch.last_byte);
			if (res_ch.valid && res_ch.ready)
				tracker.match_reply(res_ch.status, res_ch.address);
		end
	end

	// Bound the run; a hang or a lost reply ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: take replies with random back-pressure, or hold off for a long
	// stretch when asked, so that a reply parks in the block and the next last
	// byte has to wait.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic void put8(logic [7:0] v);
		frame.push_back(v);
	endfunction

	function automatic void put16(logic [15:0] v);
		frame.push_back(v[15:8]);
		frame.push_back(v[7:0]);
	endfunction

	function automatic void junk(int n);
		repeat (n) put8(8'($urandom));
	endfunction

	function automatic void put_header(logic [15:0] id, logic [15:0] flags, logic [15:0] ancount);
		put16(id);
		put16(flags);
		put16(16'd1);
		put16(ancount);
		put16(16'($urandom));
		put16(16'($urandom));
	endfunction

	// Build a name: none, a lone pointer, a label run closed by zero, or labels closed by a pointer.
	function automatic void put_name(int form);
		int n;
		if (form == NAME_NONE)
			return;
		if (form != NAME_PTR) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				put8(8'($urandom_range(1, 12)));
				junk(frame[frame.size() - 1]);
			end
		end
		if (form == NAME_LABELS) begin
			put8(8'h00);
		end else begin
			put8(PTR_MASK | 8'($urandom_range(0, 63)));
			put8(8'($urandom));
		end
	endfunction

	function automatic void put_question(int form);
		put_name(form);
		junk(QFIXED_LEN);
	endfunction

	function automatic void put_answer(logic [15:0] rtype, logic [15:0] rdlen,
			logic [31:0] addr, int form);
		put_name(form);
		put16(rtype);
		put16(16'($urandom));
		put16(16'($urandom));
		put16(16'($urandom));
		put16(rdlen);
		if (rdlen == A_DLEN) begin
			put16(addr[31:16]);
			put16(addr[15:0]);
		end else begin
			junk(rdlen);
		end
	endfunction

	// Offer one byte; idle now and then unless calm, then hold it until taken.
	task automatic push_byte(logic [7:0] b, logic tail);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.data_byte <= b;
		msg_ch.last_byte <= tail;
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Send the first keep bytes of the frame, marking the last one sent.
	task automatic send_frame(int keep);
		for (int i = 0; i < keep; i++)
			push_byte(frame[i], i == keep - 1);
		frame.delete();
	endtask

	// Drop valid, then wait until every owed reply has come back and the block is quiet.
	task automatic settle();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_txid(logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.expected_txid <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		txid_now = value;
		tracker.txid = value;
	endtask

	// One random message: mostly well-formed replies with random content, some noise,
	// some cut short, rarely one past the size limit.
	task automatic random_reply();
		int          an;
		int          keep;
		int          pick;
		logic [15:0] id;
		logic [15:0] flags;
		logic [15:0] rt;
		logic [15:0] rl;
		random_replies++;
		if ($urandom_range(99) < 8) begin
			junk($urandom_range(1, 30));
			send_frame(frame.size());
			return;
		end
		id = ($urandom_range(9) == 0) ? 16'($urandom) : txid_now;
		flags = 16'($urandom);
		if ($urandom_range(9) != 0)
			flags = flags | QR_MASK;
		if ($urandom_range(99) < 80)
			flags = flags & ~RCODE_MASK;
		pick = $urandom_range(9);
		if (pick == 0) an = 0;
		else if (pick == 1) an = $urandom_range(4, 65535);
		else an = $urandom_range(1, 3);
		put_header(id, flags, 16'(an));
		put_question($urandom_range(NAME_PTR, NAME_MIXED));
		for (int k = 0; k < an && k < 3; k++) begin
			pick = $urandom_range(9);
			if (pick < 5) rt = TYPE_A;
			else if (pick == 5) rt = 16'd28;
			else rt = 16'($urandom);
			if (rt == TYPE_A && $urandom_range(4) != 0) rl = A_DLEN;
			else rl = 16'($urandom_range(0, 6));
			put_answer(rt, rl, $urandom, $urandom_range(NAME_PTR, NAME_MIXED));
		end
		if ($urandom_range(4) == 0)
			junk($urandom_range(1, 6));
		if ($urandom_range(49) == 0)
			junk($urandom_range(MAX_MESSAGE + 1, MAX_MESSAGE + 30) - frame.size());
		keep = frame.size();
		if ($urandom_range(9) == 0)
			keep = $urandom_range(1, frame.size());
		send_frame(keep);
	endtask

	initial begin
		logic [15:0] phase_txid;
		int          phase_start;
		tracker = new();
		bytes_sent = 0;
		random_replies = 0;
		cycle_count = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		txid_now = '0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.last_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.expected_txid = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the all-ones id.
		write_txid(16'hFFFF);

		// a lone byte is too short
		put8(8'h5A);
		send_frame(1);
		// header cut one byte early is still too short
		put_header(16'hFFFF, QR_MASK, 16'd1);
		send_frame(HDR_LAST);
		// bare header: enough bytes, but no record
		put_header(16'hFFFF, QR_MASK, 16'd0);
		send_frame(HDR_LEN);
		// wrong id outranks a clear QR bit and an error code
		put_header(16'h0000, RCODE_MASK, 16'd1);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0A000001, NAME_PTR);
		send_frame(frame.size());
		// clear QR bit outranks a server error code
		put_header(16'hFFFF, RCODE_MASK, 16'd1);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0A000002, NAME_PTR);
		send_frame(frame.size());
		// server error code hides a usable record
		put_header(16'hFFFF, QR_MASK | 16'h0003, 16'd1);
		put_question(NAME_LABELS);
		put_answer(TYPE_A, A_DLEN, 32'h0A000003, NAME_PTR);
		send_frame(frame.size());
		// labeled question, pointer answer, all-ones address
		put_header(16'hFFFF, 16'h8180, 16'd1);
		put_question(NAME_LABELS);
		put_answer(TYPE_A, A_DLEN, 32'hFFFF_FFFF, NAME_PTR);
		send_frame(frame.size());
		// pointer question with no zero after it, labeled answer, zero address
		put_header(16'hFFFF, QR_MASK, 16'd1);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0000_0000, NAME_LABELS);
		send_frame(frame.size());
		// 0x40 and 0x80 are label lengths, not pointers
		put_header(16'hFFFF, 16'hFFF0, 16'd1);
		put8(8'h40);
		junk(8'h40);
		put8(8'h00);
		junk(QFIXED_LEN);
		put8(8'h80);
		junk(8'h80);
		put8(8'h00);
		put_answer(TYPE_A, A_DLEN, 32'h7F00_0001, NAME_NONE);
		send_frame(frame.size());
		// message ends inside the address: the record yields nothing
		put_header(16'hFFFF, QR_MASK, 16'd1);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0102_0304, NAME_PTR);
		send_frame(frame.size() - 2);
		// message ends inside the question
		put_header(16'hFFFF, QR_MASK, 16'd1);
		put_question(NAME_LABELS);
		send_frame(HDR_LEN + 2);
		// zero answers: a record-shaped tail is ignored
		put_header(16'hFFFF, QR_MASK, 16'd0);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0505_0505, NAME_PTR);
		send_frame(frame.size());
		// first match wins, later records are skipped
		put_header(16'hFFFF, QR_MASK, 16'd3);
		put_question(NAME_MIXED);
		put_answer(TYPE_A, A_DLEN, 32'h0102_0304, NAME_MIXED);
		put_answer(TYPE_A, A_DLEN, 32'h0506_0708, NAME_PTR);
		put_answer(16'd28, 16'd16, 32'd0, NAME_PTR);
		send_frame(frame.size());
		// A type of the wrong length, other type of length four, then the match
		put_header(16'hFFFF, QR_MASK, 16'd3);
		put_question(NAME_PTR);
		put_answer(TYPE_A, 16'd6, 32'd0, NAME_PTR);
		put_answer(16'd5, A_DLEN, 32'hDEAD_BEEF, NAME_LABELS);
		put_answer(TYPE_A, A_DLEN, 32'hC0A8_0001, NAME_PTR);
		send_frame(frame.size());
		// empty record data, then the match
		put_header(16'hFFFF, QR_MASK, 16'd2);
		put_question(NAME_PTR);
		put_answer(TYPE_A, 16'd0, 32'd0, NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0808_0808, NAME_PTR);
		send_frame(frame.size());
		// record-shaped data after the last answer is ignored
		put_header(16'hFFFF, QR_MASK, 16'd1);
		put_question(NAME_PTR);
		put_answer(16'd2, 16'd3, 32'd0, NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h0909_0909, NAME_PTR);
		send_frame(frame.size());
		// all-ones answer count: the match ends the walk
		put_header(16'hFFFF, QR_MASK, 16'hFFFF);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'h8000_0001, NAME_PTR);
		send_frame(frame.size());
		// overlong: early match, then padding well past the size limit
		put_header(16'hFFFF, QR_MASK, 16'd1);
		put_question(NAME_PTR);
		put_answer(TYPE_A, A_DLEN, 32'hC000_0201, NAME_PTR);
		junk(MAX_MESSAGE + 8 - frame.size());
		send_frame(frame.size());

		// Random part in four id settings; hold off the result side at the start of
		// the second and run without idling through the third.
		for (int p = 0; p < 4; p++) begin
			settle();
			if (p == 0) phase_txid = 16'h0000;
			else if (p == 3) phase_txid = 16'h8000;
			else phase_txid = 16'($urandom);
			write_txid(phase_txid);
			calm = (p == 2);
			if (p == 1) begin
				// keep offering bare headers so a last byte stalls behind the parked reply
				hold_request = 1'b1;
				repeat (8) begin
					put_header(txid_now, QR_MASK, 16'd0);
					send_frame(frame.size());
				end
			end
			phase_start = bytes_sent;
			while (random_replies < PHASE_REPLY * (p + 1)
					|| (p == 2 && bytes_sent - phase_start < CALM_BYTES)
					|| (p == 3 && bytes_sent < RANDOM_BYTES))
				random_reply();
		end
		calm = 1'b0;

		settle();
		if (tracker.faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
